// File: src/csl_pkg.sv
// Shared types, token kinds and character classes for the C subset lexer.
`timescale 1ns / 1ps

package csl_pkg;

  localparam int unsigned IDENT_MAX_LEN_DEF  = 31;
  localparam int unsigned STRING_MAX_LEN_DEF = 100;
  localparam int unsigned FIFO_DEPTH         = 4;
  localparam int unsigned FIFO_PTR_W         = $clog2(FIFO_DEPTH);

  localparam logic [5:0] K_IDENT     = 6'd0;
  localparam logic [5:0] K_NUMBER    = 6'd1;
  localparam logic [5:0] K_STRING    = 6'd2;
  localparam logic [5:0] K_KW_IF     = 6'd3;
  localparam logic [5:0] K_KW_ELSE   = 6'd4;
  localparam logic [5:0] K_KW_WHILE  = 6'd5;
  localparam logic [5:0] K_KW_FOR    = 6'd6;
  localparam logic [5:0] K_EOF       = 6'd40;
  localparam logic [5:0] K_ILLEGAL   = 6'd41;
  localparam logic [5:0] K_CHAR_OPEN = 6'd42;
  localparam logic [5:0] K_CHAR_MANY = 6'd43;
  localparam logic [5:0] K_STR_OPEN  = 6'd44;
  localparam logic [5:0] K_STR_LONG  = 6'd45;

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;

  localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
  localparam logic [39:0] KW_ELSE  = 40'h00_6573_6C65;
  localparam logic [39:0] KW_WHILE = 40'h65_6C69_6877;
  localparam logic [39:0] KW_FOR   = 40'h00_0072_6F66;

  typedef struct packed {
    logic [5:0]         kind;
    logic signed [31:0] value;
    logic [31:0]        start;
    logic [7:0]         len;
    logic               last;
  } token_t;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = b inside {[8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    is_space = b inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0B, 8'h0C};
  endfunction

  function automatic logic starts_op2(input logic [7:0] b);
    starts_op2 = b inside {8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3C, 8'h3E, 8'h3D, 8'h21, 8'h26,
                           8'h7C};
  endfunction

  // Illegal kind when the byte is no punctuation
  function automatic logic [5:0] punct_kind(input logic [7:0] b);
    case (b)
      "$":     punct_kind = 6'd17;
      "(":     punct_kind = 6'd18;
      ")":     punct_kind = 6'd19;
      "{":     punct_kind = 6'd20;
      "}":     punct_kind = 6'd21;
      "[":     punct_kind = 6'd22;
      "]":     punct_kind = 6'd23;
      "+":     punct_kind = 6'd24;
      "-":     punct_kind = 6'd25;
      "*":     punct_kind = 6'd26;
      "/":     punct_kind = 6'd27;
      "%":     punct_kind = 6'd28;
      "=":     punct_kind = 6'd29;
      "<":     punct_kind = 6'd30;
      ">":     punct_kind = 6'd31;
      "&":     punct_kind = 6'd32;
      "|":     punct_kind = 6'd33;
      "!":     punct_kind = 6'd34;
      ",":     punct_kind = 6'd35;
      ";":     punct_kind = 6'd36;
      ":":     punct_kind = 6'd37;
      ".":     punct_kind = 6'd38;
      "#":     punct_kind = 6'd39;
      default: punct_kind = K_ILLEGAL;
    endcase
  endfunction

  // Illegal kind when the pair is no two-character operator
  function automatic logic [5:0] op2_kind(input logic [7:0] a, input logic [7:0] b);
    case ({a, b})
      "+=":    op2_kind = 6'd7;
      "-=":    op2_kind = 6'd8;
      "*=":    op2_kind = 6'd9;
      "/=":    op2_kind = 6'd10;
      "<=":    op2_kind = 6'd11;
      ">=":    op2_kind = 6'd12;
      "==":    op2_kind = 6'd13;
      "!=":    op2_kind = 6'd14;
      "&&":    op2_kind = 6'd15;
      "||":    op2_kind = 6'd16;
      default: op2_kind = K_ILLEGAL;
    endcase
  endfunction

endpackage

// File: src/c_subset_lexer_top.sv
// Streaming C subset lexer: per-byte state update and a small token queue.
//
//  channel | direction | beat                         | handshake
//  --------+-----------+------------------------------+-----------------------
//  in      | input     | in_byte, end_of_input        | in_valid_i / in_ready_o
//  out     | output    | kind, value, start, length,  | out_valid_o / out_ready_i
//          |           | last_of_run                  |
//
// One input beat is taken per cycle; its zero to two tokens are written to a
// four-entry queue in the same edge. Input is held back only while fewer than
// two queue entries are free, so the queue drain rate sets throughput when
// every byte yields two tokens. Reset returns the lexer to idle at position 0
// and empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps

module c_subset_lexer_top #(
  parameter int unsigned IdentMaxLen  = csl_pkg::IDENT_MAX_LEN_DEF,
  parameter int unsigned StringMaxLen = csl_pkg::STRING_MAX_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         token_kind_o,
  output logic signed [31:0] token_value_o,
  output logic [31:0]        start_pos_o,
  output logic [7:0]         text_length_o,
  output logic               last_of_run_o
);
  import csl_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_IDENT  = 3'd1;
  localparam logic [2:0] M_NUMBER = 3'd2;
  localparam logic [2:0] M_CHAR   = 3'd3;
  localparam logic [2:0] M_STRING = 3'd4;
  localparam logic [2:0] M_OP     = 3'd5;

  localparam logic [7:0] IdentLim  = 8'(IdentMaxLen);
  localparam logic [7:0] StringLim = 8'(StringMaxLen);
  localparam int unsigned CntW     = $clog2(FIFO_DEPTH + 1);

  logic [2:0]  mode_q, mode_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] start_q, start_d;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  len_q, len_d;
  logic [39:0] kw_q, kw_d;
  logic        esc_q, esc_d;
  logic [1:0]  cc_q, cc_d;

  token_t      res [2];
  logic [1:0]  nres;
  logic        in_fire, out_fire;

  token_t                fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [CntW-1:0]       cnt_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  always_comb begin
    logic [7:0]  b;
    logic        do_idle;
    logic [5:0]  k;
    logic [5:0]  ident_kind;
    logic [7:0]  len_inc;
    logic [2:0]  cc_eff;

    b       = in_byte_i;
    do_idle = 1'b0;
    k       = K_ILLEGAL;
    nres    = 2'd0;
    res[0]  = '0;
    res[1]  = '0;

    mode_d  = mode_q;
    op_d    = op_q;
    acc_d   = acc_q;
    start_d = start_q;
    pos_d   = pos_q;
    len_d   = len_q;
    kw_d    = kw_q;
    esc_d   = esc_q;
    cc_d    = cc_q;

    len_inc = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
    cc_eff  = {1'b0, cc_q} + {2'b00, esc_q};

    ident_kind = K_IDENT;
    if (len_q == 8'd2 && kw_q == KW_IF) begin
      ident_kind = K_KW_IF;
    end else if (len_q == 8'd4 && kw_q == KW_ELSE) begin
      ident_kind = K_KW_ELSE;
    end else if (len_q == 8'd5 && kw_q == KW_WHILE) begin
      ident_kind = K_KW_WHILE;
    end else if (len_q == 8'd3 && kw_q == KW_FOR) begin
      ident_kind = K_KW_FOR;
    end

    if (end_of_input_i) begin
      case (mode_q)
        M_IDENT: begin
          res[0] = '{ident_kind, 32'sd0, start_q, len_q, 1'b0};
          nres   = 2'd1;
        end
        M_NUMBER: begin
          res[0] = '{K_NUMBER, acc_q, start_q, len_q, 1'b0};
          nres   = 2'd1;
        end
        M_CHAR: begin
          res[0] = '{(cc_eff >= 3'd2) ? K_CHAR_MANY : K_CHAR_OPEN, 32'sd0, start_q,
                     len_q, 1'b0};
          nres   = 2'd1;
        end
        M_STRING: begin
          res[0] = '{esc_q ? K_STR_LONG : K_STR_OPEN, 32'sd0, start_q, len_q, 1'b0};
          nres   = 2'd1;
        end
        M_OP: begin
          res[0] = '{punct_kind(op_q), 32'sd0, start_q, 8'd1, 1'b0};
          nres   = 2'd1;
        end
        default: begin
        end
      endcase
      res[nres[0]] = '{K_EOF, 32'sd0, pos_q, 8'd0, 1'b0};
      nres         = nres + 2'd1;
      mode_d       = M_IDLE;
    end else begin
      pos_d = pos_q + 32'd1;
      case (mode_q)
        M_IDENT: begin
          if (is_letter(b) || is_digit(b)) begin
            if (len_q < IdentLim) begin
              for (int i = 0; i < 5; i++) begin
                if (len_q == 8'(i)) begin
                  kw_d[8*i +: 8] = b;
                end
              end
              len_d = len_q + 8'd1;
            end
          end else begin
            res[0]  = '{ident_kind, 32'sd0, start_q, len_q, 1'b0};
            nres    = 2'd1;
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(b)) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + {28'h0, b[3:0]};
            len_d = len_inc;
          end else begin
            res[0]  = '{K_NUMBER, acc_q, start_q, len_q, 1'b0};
            nres    = 2'd1;
            do_idle = 1'b1;
          end
        end
        M_CHAR: begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (b == CH_LOWER_N || b == CH_LOWER_T) begin
              acc_d = (b == CH_LOWER_N) ? 32'd10 : 32'd9;
              len_d = len_inc;
            end else if (cc_q != 2'd3) begin
              cc_d = cc_q + 2'd1;
            end
          end else if (b == CH_SQUOTE) begin
            if (cc_q >= 2'd2) begin
              res[0] = '{K_CHAR_MANY, 32'sd0, start_q, len_q, 1'b0};
            end else begin
              res[0] = '{K_NUMBER, acc_q, start_q, len_q, 1'b0};
            end
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else if (b == CH_NL) begin
            res[0] = '{(cc_q >= 2'd2) ? K_CHAR_MANY : K_CHAR_OPEN, 32'sd0, start_q,
                       len_q, 1'b0};
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else begin
            len_d = len_inc;
            acc_d = {24'h0, b};
            if (cc_q != 2'd3) begin
              cc_d = cc_q + 2'd1;
            end
            if (b == CH_BSLASH) begin
              esc_d = 1'b1;
            end
          end
        end
        M_STRING: begin
          if (b == CH_DQUOTE || b == CH_NL) begin
            if (esc_q) begin
              k = K_STR_LONG;
            end else begin
              k = (b == CH_DQUOTE) ? K_STRING : K_STR_OPEN;
            end
            res[0] = '{k, 32'sd0, start_q, len_q, 1'b0};
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else if (len_q >= StringLim) begin
            esc_d = 1'b1;
          end else begin
            len_d = len_inc;
          end
        end
        M_OP: begin
          k = op2_kind(op_q, b);
          if (k != K_ILLEGAL) begin
            res[0] = '{k, 32'sd0, start_q, 8'd2, 1'b0};
            nres   = 2'd1;
            mode_d = M_IDLE;
          end else begin
            res[0]  = '{punct_kind(op_q), 32'sd0, start_q, 8'd1, 1'b0};
            nres    = 2'd1;
            do_idle = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        mode_d = M_IDLE;
        if (!is_space(b)) begin
          start_d = pos_q;
          if (is_letter(b)) begin
            mode_d = M_IDENT;
            len_d  = 8'd1;
            kw_d   = {32'h0, b};
          end else if (is_digit(b)) begin
            mode_d = M_NUMBER;
            len_d  = 8'd1;
            acc_d  = {28'h0, b[3:0]};
          end else if (b == CH_SQUOTE) begin
            mode_d = M_CHAR;
            len_d  = 8'd0;
            acc_d  = 32'd0;
            cc_d   = 2'd0;
            esc_d  = 1'b0;
          end else if (b == CH_DQUOTE) begin
            mode_d = M_STRING;
            len_d  = 8'd0;
            esc_d  = 1'b0;
          end else if (starts_op2(b)) begin
            mode_d = M_OP;
            op_d   = b;
          end else begin
            res[nres[0]] = '{punct_kind(b), 32'sd0, pos_q, 8'd1, 1'b0};
            nres         = nres + 2'd1;
          end
        end
      end
    end

    res[0].last = (nres == 2'd1);
    res[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      op_q    <= '0;
      acc_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
      len_q   <= '0;
      kw_q    <= '0;
      esc_q   <= 1'b0;
      cc_q    <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      op_q    <= op_d;
      acc_q   <= acc_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      kw_q    <= kw_d;
      esc_q   <= esc_d;
      cc_q    <= cc_d;
    end
  end

  // Token queue
  assign in_ready_o  = cnt_q <= CntW'(FIFO_DEPTH - 2);
  assign out_valid_o = cnt_q != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_fire) begin
        wr_q <= wr_q + FIFO_PTR_W'(nres);
      end
      if (out_fire) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (in_fire ? CntW'(nres) : '0) - CntW'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && nres != 2'd0) begin
      fifo_q[wr_q] <= res[0];
    end
    if (in_fire && nres == 2'd2) begin
      fifo_q[wr_q + 1'b1] <= res[1];
    end
  end

  assign token_kind_o  = fifo_q[rd_q].kind;
  assign token_value_o = fifo_q[rd_q].value;
  assign start_pos_o   = fifo_q[rd_q].start;
  assign text_length_o = fifo_q[rd_q].len;
  assign last_of_run_o = fifo_q[rd_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FIFO_DEPTH))
    else $error("token queue overfilled");

  a_eoi_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_input_i |-> nres != 2'd0)
    else $error("end of input gave no token");

  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_input_i |=> mode_q == M_IDLE && pos_q == $past(pos_q))
    else $error("end of input left lexer busy or moved position");

  a_pos_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !end_of_input_i |=> pos_q == $past(pos_q) + 32'd1)
    else $error("byte position did not advance");

endmodule
